// ===== hdl/bilinear_resize_u8_fixed_unit_assert.svh =====
`ifndef BILINEAR_RESIZE_U8_FIXED_UNIT_ASSERT_SVH
`define BILINEAR_RESIZE_U8_FIXED_UNIT_ASSERT_SVH

// same-cycle implication
`define BRZ_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BRZ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/brz_pkg.sv =====
package brz_pkg;

	localparam int MAX_WIDTH    = 128;
	localparam int MAX_HEIGHT   = 128;
	localparam int MAX_CHANNELS = 4;
	localparam int WEIGHT_BITS  = 11;

	localparam int CFG_SIZE_W  = 8;
	localparam int CFG_CHAN_W  = 3;
	localparam int CFG_SCALE_W = 24;
	localparam int CFG_DATA_W  = 24;
	localparam int CFG_INDEX_W = 3;

	localparam int OUT_COORD_W = 12;
	localparam int ADDR_W      = 16;
	localparam int SAMPLE_W    = 8;
	localparam int CHAN_IDX_W  = 2;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam int COORD_FRAC = 17;
	localparam int PROD_W     = OUT_COORD_W + 1 + CFG_SCALE_W;
	localparam int SPAN_W     = PROD_W - COORD_FRAC;
	localparam int ROUND_SH   = COORD_FRAC - WEIGHT_BITS;
	localparam int HALF       = 1 << (COORD_FRAC - 1);
	localparam int FULL       = 1 << WEIGHT_BITS;
	localparam int IDX_W      = $clog2((MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT);
	localparam int WGT_W      = WEIGHT_BITS + 1;
	localparam int WPROD_W    = 2 * WEIGHT_BITS + 1;
	localparam int PIX_W      = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int STEP_W     = CFG_SIZE_W + CFG_CHAN_W;
	localparam int MUL_W      = SAMPLE_W + WPROD_W;
	localparam int HSUM_W     = MUL_W + 1;
	localparam int ACC_W      = MUL_W + 2;
	localparam int OUT_SH     = 2 * WEIGHT_BITS;

	localparam logic [CFG_SIZE_W-1:0]  RST_IN_WIDTH  = CFG_SIZE_W'(128);
	localparam logic [CFG_SIZE_W-1:0]  RST_IN_HEIGHT = CFG_SIZE_W'(128);
	localparam logic [CFG_CHAN_W-1:0]  RST_CHANNELS  = CFG_CHAN_W'(1);
	localparam logic [CFG_SCALE_W-1:0] RST_SCALE     = CFG_SCALE_W'(65536);

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IN_WIDTH,
		REG_IN_HEIGHT,
		REG_CHANNELS,
		REG_SCALE_X,
		REG_SCALE_Y
	} cfg_reg_t;

	typedef enum logic {
		FUNC_LOAD,
		FUNC_PIXEL
	} func_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr_a;
		logic [ADDR_W-1:0] addr_b;
	} rd_req_t;

	typedef struct packed {
		logic                en;
		logic [ADDR_W-1:0]   addr;
		logic [SAMPLE_W-1:0] data;
	} wr_req_t;

	typedef struct packed {
		logic [IDX_W-1:0] idx;
		logic [WGT_W-1:0] w1;
	} axis_t;

	function automatic logic [CFG_SIZE_W-1:0] sat_size(logic [CFG_SIZE_W-1:0] v,
		logic [CFG_SIZE_W-1:0] hi);
		logic [CFG_SIZE_W-1:0] r;
		if (v < CFG_SIZE_W'(2)) r = CFG_SIZE_W'(2);
		else if (v > hi) r = hi;
		else r = v;
		return r;
	endfunction

	function automatic logic [CFG_CHAN_W-1:0] sat_chan(logic [CFG_CHAN_W-1:0] v);
		logic [CFG_CHAN_W-1:0] r;
		if (v == '0) r = CFG_CHAN_W'(1);
		else if (v > CFG_CHAN_W'(MAX_CHANNELS)) r = CFG_CHAN_W'(MAX_CHANNELS);
		else r = v;
		return r;
	endfunction

	// neighbour index and far weight along one axis
	function automatic axis_t axis_map(logic [PROD_W-1:0] prod, logic [CFG_SIZE_W-1:0] size);
		logic [PROD_W-1:0]     t;
		logic [SPAN_W-1:0]     s;
		logic [COORD_FRAC:0]   wr;
		axis_t                 r;
		t  = prod - PROD_W'(HALF);
		s  = t[PROD_W-1:COORD_FRAC];
		wr = {1'b0, t[COORD_FRAC-1:0]} + (COORD_FRAC+1)'(1 << (ROUND_SH - 1));
		if (prod < PROD_W'(HALF)) begin
			r.idx = '0;
			r.w1  = '0;
		end else if (s >= SPAN_W'(size - CFG_SIZE_W'(1))) begin
			r.idx = IDX_W'(size - CFG_SIZE_W'(2));
			r.w1  = WGT_W'(FULL);
		end else begin
			r.idx = s[IDX_W-1:0];
			r.w1  = wr[COORD_FRAC:ROUND_SH];
		end
		return r;
	endfunction

endpackage

// ===== hdl/brz_store.sv =====
module brz_store (
	input  logic                          clk,
	input  brz_pkg::wr_req_t              wr,
	input  brz_pkg::rd_req_t              rd,
	output logic [brz_pkg::SAMPLE_W-1:0]  rd_data_a,
	output logic [brz_pkg::SAMPLE_W-1:0]  rd_data_b
);

	logic [brz_pkg::SAMPLE_W-1:0] mem [brz_pkg::STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd.en) begin
			rd_data_a <= mem[rd.addr_a];
		end
	end

	always_ff @(posedge clk) begin
		if (rd.en) begin
			rd_data_b <= mem[rd.addr_b];
		end
	end

endmodule

// ===== hdl/bilinear_resize_u8_fixed_unit.sv =====
// channel | handshake             | payload
// --------+-----------------------+---------------------------------------------
// in      | in_valid / in_ready   | func, load_address, load_value, out_x, out_y
// out     | out_valid / out_ready | out_sample, channel, last
// cfg     | cfg_write             | cfg_index, cfg_data
//
// a load item writes the image store in the issue stage; a pixel item is read there
// per channel, set by the two read ports of the image store (two of four neighbours
// per cycle while stage 5 is not stalled)
// reset clears control and configuration; the image store is not cleared
// a stall on out_ready backs up stage by stage, in_ready falls only once stage 1 is held
module bilinear_resize_u8_fixed_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic                             func,
	input  logic [brz_pkg::ADDR_W-1:0]       load_address,
	input  logic [brz_pkg::SAMPLE_W-1:0]     load_value,
	input  logic [brz_pkg::OUT_COORD_W-1:0]  out_x,
	input  logic [brz_pkg::OUT_COORD_W-1:0]  out_y,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [brz_pkg::SAMPLE_W-1:0]     out_sample,
	output logic [brz_pkg::CHAN_IDX_W-1:0]   channel,
	output logic                             last,
	input  logic                             cfg_write,
	input  logic [brz_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [brz_pkg::CFG_DATA_W-1:0]   cfg_data
);

`include "bilinear_resize_u8_fixed_unit_assert.svh"

	// configuration
	logic [brz_pkg::CFG_SIZE_W-1:0]  width_q, height_q;
	logic [brz_pkg::CFG_CHAN_W-1:0]  chan_q;
	logic [brz_pkg::CFG_SCALE_W-1:0] scale_x_q, scale_y_q;
	logic [brz_pkg::CFG_SIZE_W-1:0]  w_sat, h_sat;
	logic [brz_pkg::CFG_CHAN_W-1:0]  c_sat;
	logic [brz_pkg::CHAN_IDX_W-1:0]  c_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q   <= brz_pkg::RST_IN_WIDTH;
			height_q  <= brz_pkg::RST_IN_HEIGHT;
			chan_q    <= brz_pkg::RST_CHANNELS;
			scale_x_q <= brz_pkg::RST_SCALE;
			scale_y_q <= brz_pkg::RST_SCALE;
		end else if (cfg_write) begin
			unique case (brz_pkg::cfg_reg_t'(cfg_index))
				brz_pkg::REG_IN_WIDTH:  width_q   <= cfg_data[brz_pkg::CFG_SIZE_W-1:0];
				brz_pkg::REG_IN_HEIGHT: height_q  <= cfg_data[brz_pkg::CFG_SIZE_W-1:0];
				brz_pkg::REG_CHANNELS:  chan_q    <= cfg_data[brz_pkg::CFG_CHAN_W-1:0];
				brz_pkg::REG_SCALE_X:   scale_x_q <= cfg_data[brz_pkg::CFG_SCALE_W-1:0];
				brz_pkg::REG_SCALE_Y:   scale_y_q <= cfg_data[brz_pkg::CFG_SCALE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign w_sat  = brz_pkg::sat_size(width_q, brz_pkg::CFG_SIZE_W'(brz_pkg::MAX_WIDTH));
	assign h_sat  = brz_pkg::sat_size(height_q, brz_pkg::CFG_SIZE_W'(brz_pkg::MAX_HEIGHT));
	assign c_sat  = brz_pkg::sat_chan(chan_q);
	assign c_last = brz_pkg::CHAN_IDX_W'(c_sat - brz_pkg::CFG_CHAN_W'(1));

	// stage valids and enables
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic en1, en2, en3, rdy4, en5, en6;
	logic issue, done4, out_free, req_s4;

	// payload registers
	brz_pkg::func_t                func_s1, func_s2, func_s3, func_s4;
	logic [brz_pkg::ADDR_W-1:0]    laddr_s1, laddr_s2, laddr_s3, laddr_s4;
	logic [brz_pkg::SAMPLE_W-1:0]  lval_s1, lval_s2, lval_s3, lval_s4;
	logic [brz_pkg::PROD_W-1:0]    prodx_s1, prody_s1;
	brz_pkg::axis_t                ax_s2, ay_s2;
	logic [brz_pkg::PIX_W-1:0]     pix_s3;
	logic [brz_pkg::WPROD_W-1:0]   p00_s3, p01_s3, p10_s3, p11_s3;
	logic [brz_pkg::WPROD_W-1:0]   p00_s4, p01_s4, p10_s4, p11_s4;
	logic [brz_pkg::ADDR_W-1:0]    base_s4;
	logic [brz_pkg::STEP_W-1:0]    step_s4;
	logic [brz_pkg::CHAN_IDX_W-1:0] k_q;
	logic                          half_q;
	logic [brz_pkg::WPROD_W-1:0]   wa_s5, wb_s5;
	logic [brz_pkg::CHAN_IDX_W-1:0] k_s5, k_s6;
	logic                          half_s5, half_s6, last_s5, last_s6;
	logic [brz_pkg::HSUM_W-1:0]    psum_s6, acc_q;

	logic [brz_pkg::PROD_W-1:0]    prodx_d, prody_d;
	logic [brz_pkg::WGT_W-1:0]     wx0, wy0;
	logic [brz_pkg::ADDR_W-1:0]    addr_a, addr_b;
	logic [brz_pkg::SAMPLE_W-1:0]  rd_a, rd_b;
	logic [brz_pkg::HSUM_W-1:0]    psum_d;
	logic [brz_pkg::ACC_W-1:0]     total;
	logic [brz_pkg::SAMPLE_W-1:0]  sample_d;

	logic                          out_valid_q, last_q;
	logic [brz_pkg::SAMPLE_W-1:0]  out_sample_q;
	logic [brz_pkg::CHAN_IDX_W-1:0] channel_q;

	brz_pkg::rd_req_t rd_req;
	brz_pkg::wr_req_t wr_req;

	assign out_free = !out_valid_q || out_ready;
	assign en6      = !v_s6 || !half_s6 || out_free;
	assign en5      = !v_s5 || en6;
	assign req_s4   = (func_s4 == brz_pkg::FUNC_PIXEL);
	assign issue    = v_s4 && req_s4 && en5;
	assign done4    = v_s4 && (!req_s4 || (issue && half_q && (k_q == c_last)));
	assign rdy4     = !v_s4 || done4;
	assign en3      = !v_s3 || rdy4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			k_q         <= '0;
			half_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (rdy4) begin
				v_s4   <= v_s3;
				k_q    <= '0;
				half_q <= 1'b0;
			end else if (issue) begin
				if (half_q) begin
					half_q <= 1'b0;
					k_q    <= k_q + brz_pkg::CHAN_IDX_W'(1);
				end else begin
					half_q <= 1'b1;
				end
			end
			if (en5) v_s5 <= issue;
			if (en6) v_s6 <= v_s5;
			if (out_free) out_valid_q <= v_s6 && half_s6;
		end
	end

	// stage 1: coordinate products (2*out+1)*scale
	assign prodx_d = brz_pkg::PROD_W'({out_x, 1'b1}) * brz_pkg::PROD_W'(scale_x_q);
	assign prody_d = brz_pkg::PROD_W'({out_y, 1'b1}) * brz_pkg::PROD_W'(scale_y_q);

	// stage 3: weights
	assign wx0 = brz_pkg::WGT_W'(brz_pkg::FULL) - ax_s2.w1;
	assign wy0 = brz_pkg::WGT_W'(brz_pkg::FULL) - ay_s2.w1;

	always_ff @(posedge clk) begin
		if (en1) begin
			func_s1  <= brz_pkg::func_t'(func);
			laddr_s1 <= load_address;
			lval_s1  <= load_value;
			prodx_s1 <= prodx_d;
			prody_s1 <= prody_d;
		end
		if (en2) begin
			func_s2  <= func_s1;
			laddr_s2 <= laddr_s1;
			lval_s2  <= lval_s1;
			ax_s2    <= brz_pkg::axis_map(prodx_s1, w_sat);
			ay_s2    <= brz_pkg::axis_map(prody_s1, h_sat);
		end
		if (en3) begin
			func_s3  <= func_s2;
			laddr_s3 <= laddr_s2;
			lval_s3  <= lval_s2;
			pix_s3   <= brz_pkg::PIX_W'(brz_pkg::PIX_W'(ay_s2.idx) * brz_pkg::PIX_W'(w_sat)
				+ brz_pkg::PIX_W'(ax_s2.idx));
			p00_s3   <= brz_pkg::WPROD_W'(wx0) * brz_pkg::WPROD_W'(wy0);
			p01_s3   <= brz_pkg::WPROD_W'(wx0) * brz_pkg::WPROD_W'(ay_s2.w1);
			p10_s3   <= brz_pkg::WPROD_W'(ax_s2.w1) * brz_pkg::WPROD_W'(wy0);
			p11_s3   <= brz_pkg::WPROD_W'(ax_s2.w1) * brz_pkg::WPROD_W'(ay_s2.w1);
		end
		if (rdy4) begin
			func_s4  <= func_s3;
			laddr_s4 <= laddr_s3;
			lval_s4  <= lval_s3;
			base_s4  <= brz_pkg::ADDR_W'(brz_pkg::ADDR_W'(pix_s3) * brz_pkg::ADDR_W'(c_sat));
			step_s4  <= brz_pkg::STEP_W'(w_sat) * brz_pkg::STEP_W'(c_sat);
			p00_s4   <= p00_s3;
			p01_s4   <= p01_s3;
			p10_s4   <= p10_s3;
			p11_s4   <= p11_s3;
		end
		if (issue) begin
			wa_s5   <= half_q ? p01_s4 : p00_s4;
			wb_s5   <= half_q ? p11_s4 : p10_s4;
			k_s5    <= k_q;
			half_s5 <= half_q;
			last_s5 <= (k_q == c_last);
		end
		if (en6) begin
			psum_s6 <= psum_d;
			k_s6    <= k_s5;
			half_s6 <= half_s5;
			last_s6 <= last_s5;
		end
		if (v_s6 && !half_s6) begin
			acc_q <= psum_s6;
		end
		if (out_free && v_s6 && half_s6) begin
			out_sample_q <= sample_d;
			channel_q    <= k_s6;
			last_q       <= last_s6;
		end
	end

	// stage 4: issue, top pair then bottom pair of each channel
	assign addr_a = base_s4 + brz_pkg::ADDR_W'(k_q)
		+ (half_q ? brz_pkg::ADDR_W'(step_s4) : '0);
	assign addr_b = addr_a + brz_pkg::ADDR_W'(c_sat);

	assign rd_req.en     = issue;
	assign rd_req.addr_a = addr_a;
	assign rd_req.addr_b = addr_b;
	assign wr_req.en     = v_s4 && !req_s4;
	assign wr_req.addr   = laddr_s4;
	assign wr_req.data   = lval_s4;

	brz_store u_store (
		.clk       (clk),
		.wr        (wr_req),
		.rd        (rd_req),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	// stage 5 to 6: weighted pair
	assign psum_d = brz_pkg::HSUM_W'(brz_pkg::MUL_W'(rd_a) * brz_pkg::MUL_W'(wa_s5))
		+ brz_pkg::HSUM_W'(brz_pkg::MUL_W'(rd_b) * brz_pkg::MUL_W'(wb_s5));

	// output: both pairs summed, scaled and clipped
	assign total = brz_pkg::ACC_W'(acc_q) + brz_pkg::ACC_W'(psum_s6);
	assign sample_d = (|total[brz_pkg::ACC_W-1:brz_pkg::OUT_SH+brz_pkg::SAMPLE_W])
		? '1 : total[brz_pkg::OUT_SH+brz_pkg::SAMPLE_W-1:brz_pkg::OUT_SH];

	assign out_valid  = out_valid_q;
	assign out_sample = out_sample_q;
	assign channel    = channel_q;
	assign last       = last_q;

	`BRZ_ASSERT_NOW(a_last_chan, out_valid_q && last_q, channel_q == c_last, "last flag on wrong channel")
	`BRZ_ASSERT_NEXT(a_half_pair, v_s6 && !half_s6, v_s6 && half_s6 && (k_s6 == $past(k_s6)), "top pair not followed by bottom pair")
	`BRZ_ASSERT_NEXT(a_issue_hold, v_s4 && req_s4 && !en5, v_s4 && $stable(k_q) && $stable(half_q), "issue counter moved while stalled")

endmodule

// ===== verif/bilinear_resize_u8_fixed_checker.sv =====
`timescale 1ns / 100ps
module bilinear_resize_u8_fixed_checker
	import brz_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   in_ready,
	input  logic                   func,
	input  logic [ADDR_W-1:0]      load_address,
	input  logic [SAMPLE_W-1:0]    load_value,
	input  logic [OUT_COORD_W-1:0] out_x,
	input  logic [OUT_COORD_W-1:0] out_y,
	input  logic                   out_valid,
	input  logic                   out_ready,
	input  logic [SAMPLE_W-1:0]    out_sample,
	input  logic [CHAN_IDX_W-1:0]  channel,
	input  logic                   last,
	input  logic                   cfg_write,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output int                     errors,
	output int                     pending,
	output int                     loads_seen,
	output int                     pixels_seen,
	output int                     results_seen
);

	typedef struct packed {
		logic [SAMPLE_W-1:0]   sample;
		logic [CHAN_IDX_W-1:0] chan;
		logic                  last;
	} chan_sample_t;

	logic [SAMPLE_W-1:0]    image_mem [0:STORE_DEPTH-1];
	logic [CFG_SIZE_W-1:0]  width_reg;
	logic [CFG_SIZE_W-1:0]  height_reg;
	logic [CFG_CHAN_W-1:0]  chan_reg;
	logic [CFG_SCALE_W-1:0] scale_x_reg;
	logic [CFG_SCALE_W-1:0] scale_y_reg;
	chan_sample_t           expected_samples_q [$];
	int                     fail_count = 0;
	int                     load_count = 0;
	int                     pixel_count = 0;
	int                     result_count = 0;

	// top/left neighbour and far weight along one axis
	function automatic void map_axis(input int unsigned pos, input int unsigned scale,
		input int unsigned size, output int unsigned idx, output int unsigned w_far);
		longint unsigned prod;
		longint unsigned t;
		longint unsigned s;
		int unsigned     frac;
		prod = (64'(pos) * 2 + 1) * 64'(scale);
		if (prod < HALF) begin
			idx = 0;
			w_far = 0;
		end else begin
			t = prod - HALF;
			s = t >> COORD_FRAC;
			frac = int'(t & ((64'(1) << COORD_FRAC) - 1));
			w_far = (frac + (1 << (ROUND_SH - 1))) >> ROUND_SH;
			if (w_far > FULL) w_far = FULL;
			if (s >= size - 1) begin
				idx = size - 2;
				w_far = FULL;
			end else begin
				idx = int'(s);
			end
		end
	endfunction

	function automatic longint unsigned src_sample(int unsigned row, int unsigned col,
		int unsigned k, int unsigned w, int unsigned c);
		return 64'(image_mem[ADDR_W'((row * w + col) * c + k)]);
	endfunction

	task automatic interpolate_pixel(input logic [OUT_COORD_W-1:0] ox,
		input logic [OUT_COORD_W-1:0] oy);
		int unsigned     w, h, c;
		int unsigned     sx, sy, wx0, wx1, wy0, wy1;
		longint unsigned acc;
		chan_sample_t    r;
		w = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
		h = (height_reg < 2) ? 2 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg);
		c = (chan_reg == 0) ? 1 : ((chan_reg > MAX_CHANNELS) ? MAX_CHANNELS : chan_reg);
		map_axis(ox, scale_x_reg, w, sx, wx1);
		map_axis(oy, scale_y_reg, h, sy, wy1);
		wx0 = FULL - wx1;
		wy0 = FULL - wy1;
		for (int unsigned k = 0; k < c; k++) begin
			acc = src_sample(sy, sx, k, w, c) * wx0 * wy0
				+ src_sample(sy + 1, sx, k, w, c) * wx0 * wy1
				+ src_sample(sy, sx + 1, k, w, c) * wx1 * wy0
				+ src_sample(sy + 1, sx + 1, k, w, c) * wx1 * wy1;
			acc = acc >> OUT_SH;
			if (acc > 255) acc = 255;
			r.sample = acc[SAMPLE_W-1:0];
			r.chan = k[CHAN_IDX_W-1:0];
			r.last = (k + 1 == c);
			expected_samples_q.push_back(r);
		end
	endtask

	task automatic compare_field(input string name, input logic [SAMPLE_W-1:0] want,
		input logic [SAMPLE_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		chan_sample_t want;
		if (!arst_n) begin
			width_reg = RST_IN_WIDTH;
			height_reg = RST_IN_HEIGHT;
			chan_reg = RST_CHANNELS;
			scale_x_reg = RST_SCALE;
			scale_y_reg = RST_SCALE;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					REG_IN_WIDTH:  width_reg = cfg_data[CFG_SIZE_W-1:0];
					REG_IN_HEIGHT: height_reg = cfg_data[CFG_SIZE_W-1:0];
					REG_CHANNELS:  chan_reg = cfg_data[CFG_CHAN_W-1:0];
					REG_SCALE_X:   scale_x_reg = cfg_data[CFG_SCALE_W-1:0];
					REG_SCALE_Y:   scale_y_reg = cfg_data[CFG_SCALE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (func_t'(func) == FUNC_LOAD) begin
					image_mem[load_address] = load_value;
					load_count++;
				end else begin
					interpolate_pixel(out_x, out_y);
					pixel_count++;
				end
			end
			if (out_valid && out_ready) begin
				result_count++;
				if (expected_samples_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, got sample %0d channel %0d",
						$time, out_sample, channel);
					fail_count++;
				end else begin
					want = expected_samples_q.pop_front();
					compare_field("out_sample", want.sample, out_sample);
					compare_field("channel", SAMPLE_W'(want.chan), SAMPLE_W'(channel));
					compare_field("last", SAMPLE_W'(want.last), SAMPLE_W'(last));
				end
			end
		end
		errors <= fail_count;
		pending <= expected_samples_q.size();
		loads_seen <= load_count;
		pixels_seen <= pixel_count;
		results_seen <= result_count;
	end

endmodule

// ===== verif/bilinear_resize_u8_fixed_unit_tb.sv =====
`timescale 1ns / 100ps
module bilinear_resize_u8_fixed_unit_tb;
	import brz_pkg::*;

	localparam int STALL_PCT      = 36;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 16;
	localparam int SCALE_MAX      = 8388608;
	localparam int SCALE_ONE      = 65536;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_ready;
	logic                   func;
	logic [ADDR_W-1:0]      load_address;
	logic [SAMPLE_W-1:0]    load_value;
	logic [OUT_COORD_W-1:0] out_x;
	logic [OUT_COORD_W-1:0] out_y;
	logic                   out_valid;
	logic                   out_ready;
	logic [SAMPLE_W-1:0]    out_sample;
	logic [CHAN_IDX_W-1:0]  channel;
	logic                   last;
	logic                   cfg_write;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	int check_errors;
	int results_pending;
	int loads_seen;
	int pixels_seen;
	int results_seen;

	bit          burst;
	bit          sample_loaded [0:STORE_DEPTH-1];
	int unsigned eff_width, eff_height, eff_chan;
	int unsigned cur_scale_x, cur_scale_y;
	int          items_sent;
	int          settings_run;
	int          quiet_cycles;

	bilinear_resize_u8_fixed_unit uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .load_address(load_address), .load_value(load_value),
		.out_x(out_x), .out_y(out_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_sample(out_sample), .channel(channel), .last(last),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	bilinear_resize_u8_fixed_checker checker_i (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .load_address(load_address), .load_value(load_value),
		.out_x(out_x), .out_y(out_y),
		.out_valid(out_valid), .out_ready(out_ready),
		.out_sample(out_sample), .channel(channel), .last(last),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.errors(check_errors), .pending(results_pending),
		.loads_seen(loads_seen), .pixels_seen(pixels_seen), .results_seen(results_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			out_ready <= burst || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("[bilinear_resize_u8_fixed_unit] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic int unsigned rand_sample();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 255;
			default: return $urandom_range(0, 255);
		endcase
	endfunction

	function automatic int unsigned rand_scale();
		case ($urandom_range(0, 9))
			0: return 1;
			1: return SCALE_MAX;
			2, 3: return $urandom_range(1, SCALE_MAX);
			default: return $urandom_range(SCALE_ONE / 4, 3 * SCALE_ONE);
		endcase
	endfunction

	function automatic int unsigned rand_coord(int unsigned scale, int unsigned size);
		int unsigned span;
		span = (size * SCALE_ONE) / scale + 2;
		if (span > 4095) span = 4095;
		case ($urandom_range(0, 9))
			0: return 0;
			1: return 4095;
			2: return $urandom_range(0, 4095);
			default: return $urandom_range(0, span);
		endcase
	endfunction

	// left or top source index that a request will read
	function automatic int unsigned source_index(int unsigned pos, int unsigned scale,
		int unsigned size);
		longint unsigned prod;
		longint unsigned s;
		prod = (64'(pos) * 2 + 1) * 64'(scale);
		if (prod < HALF) return 0;
		s = (prod - HALF) >> COORD_FRAC;
		return (s >= size - 1) ? size - 2 : int'(s);
	endfunction

	task automatic send_item(input func_t f, input int unsigned addr, input int unsigned val,
		input int unsigned x, input int unsigned y);
		while (!burst && $urandom_range(0, 99) < STALL_PCT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		load_address <= ADDR_W'(addr);
		load_value <= SAMPLE_W'(val);
		out_x <= OUT_COORD_W'(x);
		out_y <= OUT_COORD_W'(y);
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	task automatic load_sample(input int unsigned addr, input int unsigned val);
		send_item(FUNC_LOAD, addr, val, $urandom_range(0, 4095), $urandom_range(0, 4095));
		sample_loaded[ADDR_W'(addr)] = 1'b1;
	endtask

	// make sure every sample the request reads has been written first
	task automatic request_pixel(input int unsigned x, input int unsigned y);
		int unsigned sx, sy, a;
		sx = source_index(x, cur_scale_x, eff_width);
		sy = source_index(y, cur_scale_y, eff_height);
		for (int unsigned dy = 0; dy < 2; dy++)
			for (int unsigned dx = 0; dx < 2; dx++)
				for (int unsigned k = 0; k < eff_chan; k++) begin
					a = ((sy + dy) * eff_width + sx + dx) * eff_chan + k;
					if (!sample_loaded[a]) load_sample(a, rand_sample());
				end
		send_item(FUNC_PIXEL, $urandom_range(0, 65535), $urandom_range(0, 255), x, y);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_pending != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input int unsigned data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(data);
		@(posedge clk);
	endtask

	task automatic configure(input int unsigned w, input int unsigned h, input int unsigned c,
		input int unsigned scx, input int unsigned scy);
		write_reg(REG_IN_WIDTH, w);
		write_reg(REG_IN_HEIGHT, h);
		write_reg(REG_CHANNELS, c);
		write_reg(REG_SCALE_X, scx);
		write_reg(REG_SCALE_Y, scy);
		cfg_write <= 1'b0;
		eff_width = (w < 2) ? 2 : ((w > MAX_WIDTH) ? MAX_WIDTH : w);
		eff_height = (h < 2) ? 2 : ((h > MAX_HEIGHT) ? MAX_HEIGHT : h);
		eff_chan = (c == 0) ? 1 : ((c > MAX_CHANNELS) ? MAX_CHANNELS : c);
		cur_scale_x = scx;
		cur_scale_y = scy;
		settings_run++;
	endtask

	initial begin : stimulus
		int unsigned cw, ch, cc, csx, csy;
		int          budget;
		int          start;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_LOAD;
		load_address = '0;
		load_value = '0;
		out_x = '0;
		out_y = '0;
		cfg_write = 1'b0;
		cfg_index = REG_IN_WIDTH;
		cfg_data = '0;
		burst = 1'b0;
		items_sent = 0;
		settings_run = 1;
		eff_width = RST_IN_WIDTH;
		eff_height = RST_IN_HEIGHT;
		eff_chan = RST_CHANNELS;
		cur_scale_x = RST_SCALE;
		cur_scale_y = RST_SCALE;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: store address extremes, origin and far corner
		load_sample(16'hFFFF, 255);
		load_sample(0, 0);
		request_pixel(0, 0);
		request_pixel(4095, 4095);
		drain();

		// x fraction rounds up to full weight, y lands below zero
		configure(3, 3, 2, 3 * SCALE_ONE - 10, 1);
		request_pixel(0, 0);
		request_pixel(4095, 0);
		drain();

		for (int p = 0; p < 10; p++) begin
			budget = 30;
			csx = rand_scale();
			csy = rand_scale();
			case (p)
				0: begin cw = 4; ch = 3; cc = 1; end
				1: begin cw = 5; ch = 5; cc = 3; end
				2: begin cw = 0; ch = 255; cc = 2; csx = SCALE_MAX; csy = 1; budget = 20; end
				3: begin cw = 1; ch = 6; cc = 7; end
				4: begin cw = 128; ch = 128; cc = 1; end
				5: begin cw = 6; ch = 4; cc = 0; end
				6: begin cw = 3; ch = 8; cc = 4; end
				7: begin cw = 128; ch = 2; cc = 4; csx = 1; csy = SCALE_MAX; budget = 20; end
				8: begin cw = 7; ch = 7; cc = 2; budget = 40; end
				default: begin cw = 2; ch = 2; cc = 1; csx = SCALE_ONE; csy = SCALE_ONE; end
			endcase
			configure(cw, ch, cc, csx, csy);
			burst = (p == 8);
			start = items_sent;
			while (items_sent - start < budget) begin
				if ($urandom_range(0, 4) == 0)
					load_sample($urandom_range(0, 65535), rand_sample());
				else
					request_pixel(rand_coord(cur_scale_x, eff_width),
						rand_coord(cur_scale_y, eff_height));
			end
			burst = 1'b0;
			drain();
		end

		$display("covered %0d sample loads and %0d pixel requests giving %0d results",
			loads_seen, pixels_seen, results_seen);
		$display("over %0d register settings incl. saturated sizes and channel counts",
			settings_run);
		if (check_errors == 0 && results_pending == 0)
			$display("[bilinear_resize_u8_fixed_unit] OK");
		else
			$display("[bilinear_resize_u8_fixed_unit] ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/brz_pkg.sv
hdl/brz_store.sv
hdl/bilinear_resize_u8_fixed_unit.sv
verif/bilinear_resize_u8_fixed_checker.sv
verif/bilinear_resize_u8_fixed_unit_tb.sv
